// ===== sv/ths_pkg.sv =====
// ----------------------------------------------------------------------------
// ths_pkg
// Shared types and constants for the terrain height snap block.
// ----------------------------------------------------------------------------
package ths_pkg;

   // store size default
   localparam int MAX_VERTICES_DEF = 1024;

   // field widths
   localparam int XY_W       = 32;
   localparam int IDX_W      = 10;
   localparam int SIZE_W     = 31;
   localparam int COUNT_W    = 11;
   localparam int TOL_W      = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   // distance and weight widths
   localparam int D2_W  = 49;
   localparam int DEN_W = 50;
   localparam int QUO_W = 41;
   localparam int W_W   = 32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_VERTEX_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT_TOL   = 2'd1;

   // request operations
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // constants in Q16.16
   localparam logic [TOL_W-1:0]  TOL_RESET  = 17'd6554;
   localparam logic [6:0]        EPS_Q16    = 7'd66;
   localparam logic signed [17:0] BLEND_MEAN = 18'sd45875;
   localparam logic signed [17:0] BLEND_NEAR = 18'sd19661;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_SCAN,
      ST_DRAIN,
      ST_DIV,
      ST_BLEND,
      ST_SUM,
      ST_CHECK,
      ST_RESP
   } ths_state_type;

   // one in-range vertex entering the weight unit
   typedef struct packed {
      logic                   valid;
      logic [D2_W-1:0]        d2;
      logic signed [XY_W-1:0] y;
   } wreq_type;

   // clamped weight leaving the weight unit
   typedef struct packed {
      logic                   valid;
      logic [W_W-1:0]         w;
      logic signed [XY_W-1:0] y;
   } wres_type;

endpackage

// ===== sv/ths_weight_pipe.sv =====
// ----------------------------------------------------------------------------
// ths_weight_pipe
// Pipelined restoring divider forming w = 2^40 / (d2 + eps), one quotient
// bit per stage, clamped to [1, 2^32-1]. Accepts one vertex per cycle.
// ----------------------------------------------------------------------------
module ths_weight_pipe (
   input  logic              clock,
   input  logic              reset,
   input  ths_pkg::wreq_type in_req,
   output ths_pkg::wres_type out_res,
   output logic              busy
);
   import ths_pkg::*;

   logic [QUO_W-1:0]       v_ff;
   logic [DEN_W-1:0]       rem_ff [QUO_W];
   logic [DEN_W-1:0]       den_ff [QUO_W];
   logic [QUO_W-1:0]       quo_ff [QUO_W];
   logic signed [XY_W-1:0] y_ff   [QUO_W];
   wres_type               res_ff;
   logic [QUO_W-1:0]       q_last;
   logic [W_W-1:0]         w_in;

   // one quotient bit per stage, dividend has only bit 40 set
   for (genvar s = 0; s < QUO_W; s++) begin : g_step
      logic [DEN_W-1:0]       p_rem;
      logic [DEN_W-1:0]       p_den;
      logic [QUO_W-1:0]       p_quo;
      logic signed [XY_W-1:0] p_y;
      logic                   p_v;
      logic                   nbit;
      logic [DEN_W:0]         trial;
      logic                   ge;

      if (s == 0) begin : g_first
         assign p_rem = '0;
         assign p_den = DEN_W'(in_req.d2) + DEN_W'(EPS_Q16);
         assign p_quo = '0;
         assign p_y   = in_req.y;
         assign p_v   = in_req.valid;
         assign nbit  = 1'b1;
      end else begin : g_next
         assign p_rem = rem_ff[s-1];
         assign p_den = den_ff[s-1];
         assign p_quo = quo_ff[s-1];
         assign p_y   = y_ff[s-1];
         assign p_v   = v_ff[s-1];
         assign nbit  = 1'b0;
      end

      assign trial = {p_rem, nbit};
      assign ge    = trial >= {1'b0, p_den};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else begin
            v_ff[s] <= p_v;
         end
         rem_ff[s] <= ge ? DEN_W'(trial - {1'b0, p_den}) : DEN_W'(trial);
         den_ff[s] <= p_den;
         quo_ff[s] <= {p_quo[QUO_W-2:0], ge};
         y_ff[s]   <= p_y;
      end
   end

   // clamp the weight into [1, 2^32-1]
   assign q_last = quo_ff[QUO_W-1];
   always_comb begin
      if (q_last[QUO_W-1:W_W] != '0) begin
         w_in = '1;
      end else if (q_last == '0) begin
         w_in = W_W'(1);
      end else begin
         w_in = q_last[W_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff.valid <= 1'b0;
      end else begin
         res_ff.valid <= v_ff[QUO_W-1];
      end
      res_ff.w <= w_in;
      res_ff.y <= y_ff[QUO_W-1];
   end

   assign out_res = res_ff;
   assign busy    = (|v_ff) | res_ff.valid;

endmodule

// ===== sv/ths_mean_div.sv =====
// ----------------------------------------------------------------------------
// ths_mean_div
// Iterative restoring divider, 64-bit dividend by DEN_W-bit divisor,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ths_mean_div #(
   parameter int DEN_W = 43
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [63:0]      dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output logic [63:0]      quotient
);
   logic             busy_ff;
   logic             done_ff;
   logic [5:0]       cnt_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [63:0]      quo_ff;
   logic [DEN_W:0]   trial;
   logic             ge;

   assign trial = {rem_ff, quo_ff[63]};
   assign ge    = trial >= {1'b0, den_ff};

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // shift-subtract datapath, dividend shifts out as quotient shifts in
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         den_ff <= divisor;
         quo_ff <= dividend;
      end else if (busy_ff) begin
         rem_ff <= ge ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
         quo_ff <= {quo_ff[62:0], ge};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== sv/terrain_height_snap.sv =====
// ----------------------------------------------------------------------------
// terrain_height_snap
// Vertex store plus inverse-distance weighted height query and snap.
// ----------------------------------------------------------------------------
// A load request writes the vertex into the store. A query request scans
// vertex_count stored vertices, one store read per cycle. Its response follows
// the scan, the draining of the distance and weight pipeline and, when a vertex
// is in range, the final mean division and the blend and compare states. A
// disabled body's query skips all of these and goes straight to the response
// state. One request is worked on at a time; a finished response waits in the
// output register while the next request is taken. Slots must be loaded before
// a query scans them.
module terrain_height_snap
   import ths_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_op,
   input  logic [ths_pkg::IDX_W-1:0]    req_vertex_index,
   input  logic signed [ths_pkg::XY_W-1:0] req_coord_x,
   input  logic signed [ths_pkg::XY_W-1:0] req_coord_y,
   input  logic signed [ths_pkg::XY_W-1:0] req_coord_z,
   input  logic [ths_pkg::SIZE_W-1:0]   req_size_x,
   input  logic [ths_pkg::SIZE_W-1:0]   req_size_y,
   input  logic signed [ths_pkg::XY_W-1:0] req_velocity_y,
   input  logic                         req_collision_enabled,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_hit,
   output logic signed [ths_pkg::XY_W-1:0] rsp_new_pos_y,
   output logic signed [ths_pkg::XY_W-1:0] rsp_new_vel_y,
   input  logic                         csr_we,
   input  logic [ths_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ths_pkg::CSR_DATA_W-1:0] csr_wdata
);
   localparam int AW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CW   = $clog2(MAX_VERTICES + 1);
   localparam int WS_W = W_W + $clog2(MAX_VERTICES + 1);

   ths_state_type state_ff, state_in;

   // configuration
   logic [COUNT_W-1:0] vcount_ff;
   logic [TOL_W-1:0]   tol_ff;

   // query context
   logic signed [XY_W-1:0] px_ff, py_ff, pz_ff;
   logic [SIZE_W-1:0]      sy_ff;
   logic [31:0]            r_ff;
   logic [47:0]            r2_ff;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          idx_ff;

   // memories
   logic [63:0]            plane_mem  [MAX_VERTICES];
   logic [XY_W-1:0]        height_mem [MAX_VERTICES];
   logic [63:0]            rd_plane_ff;
   logic [XY_W-1:0]        rd_height_ff;

   // scan pipeline
   logic                   rd_v_ff, ab_v_ff, sq_v_ff, d2_v_ff;
   logic [31:0]            ax_ff, az_ff;
   logic signed [XY_W-1:0] y_ab_ff, y_sq_ff, y_d2_ff;
   logic [63:0]            sqx_ff, sqz_ff;
   logic [D2_W-1:0]        d2_ff, d2_in;
   logic                   inr_ff;
   logic [XY_W:0]          dx, dz;

   // nearest and sums
   logic                   found_ff;
   logic [D2_W-1:0]        best_ff;
   logic signed [XY_W-1:0] near_y_ff;
   wreq_type               wreq;
   wres_type               wres;
   logic                   wp_busy;
   logic                   mul_v_ff;
   logic signed [63:0]     prod_ff;
   logic [W_W-1:0]         wmul_ff;
   logic signed [63:0]     wy_sum_ff;
   logic [WS_W-1:0]        w_sum_ff;
   logic signed [64:0]     acc_sum;
   logic signed [64:0]     prod_full;

   // final stages
   logic [63:0]            mag;
   logic                   div_done;
   logic [63:0]            quo;
   logic signed [XY_W-1:0] mean_ff, mean_in;
   logic signed [49:0]     pm_ff, pn_ff;
   logic signed [50:0]     blend_sum;
   logic signed [34:0]     h_ff;
   logic signed [36:0]     top, bottom, py_ext;

   // result registers
   logic                   res_hit_ff;
   logic signed [XY_W-1:0] res_pos_ff, res_vel_ff;
   logic                   rsp_valid_ff, rsp_hit_ff;
   logic signed [XY_W-1:0] rsp_pos_ff, rsp_vel_ff;

   // control strobes
   logic req_take, query_take, scan_issue, pipe_busy, div_start, rsp_load;

   assign req_take   = req_valid & req_ready;
   assign query_take = req_take & (req_op == OP_QUERY);
   assign pipe_busy  = rd_v_ff | ab_v_ff | sq_v_ff | d2_v_ff | wp_busy | mul_v_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= '0;
         tol_ff    <= TOL_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_VERTEX_COUNT: vcount_ff <= csr_wdata[COUNT_W-1:0];
            REG_HEIGHT_TOL:   tol_ff    <= csr_wdata[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (query_take) state_in = req_collision_enabled ? ST_PREP : ST_RESP;
         end
         ST_PREP:  state_in = ST_SCAN;
         ST_SCAN: begin
            if (idx_ff >= count_ff) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!pipe_busy) state_in = found_ff ? ST_DIV : ST_RESP;
         end
         ST_DIV: begin
            if (div_done) state_in = ST_BLEND;
         end
         ST_BLEND: state_in = ST_SUM;
         ST_SUM:   state_in = ST_CHECK;
         ST_CHECK: state_in = ST_RESP;
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready  = (state_ff == ST_IDLE);
      scan_issue = (state_ff == ST_SCAN) && (idx_ff < count_ff);
      div_start  = (state_ff == ST_DRAIN) && !pipe_busy && found_ff;
      rsp_load   = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // vertex store: write on load, registered read during scan
   always_ff @(posedge clock) begin
      if (req_take && (req_op == OP_LOAD) &&
          (32'(req_vertex_index) < 32'(MAX_VERTICES))) begin
         plane_mem[AW'(req_vertex_index)]  <= {req_coord_z, req_coord_x};
         height_mem[AW'(req_vertex_index)] <= req_coord_y;
      end
      rd_plane_ff  <= plane_mem[idx_ff[AW-1:0]];
      rd_height_ff <= height_mem[idx_ff[AW-1:0]];
   end

   // scan count clamped to store size
   always_comb begin
      if (32'(vcount_ff) > 32'(MAX_VERTICES)) count_in = CW'(MAX_VERTICES);
      else                                    count_in = CW'(vcount_ff);
   end

   // query capture, radius, scan index
   always_ff @(posedge clock) begin
      if (query_take) begin
         px_ff    <= req_coord_x;
         py_ff    <= req_coord_y;
         pz_ff    <= req_coord_z;
         sy_ff    <= req_size_y;
         r_ff     <= 32'((33'(req_size_x) * 33'd3) >> 1);
         count_ff <= count_in;
      end
      if (state_ff == ST_PREP) begin
         r2_ff <= 48'((64'(r_ff) * 64'(r_ff)) >> 16);
      end
      if (state_ff == ST_PREP)  idx_ff <= '0;
      else if (scan_issue)      idx_ff <= idx_ff + CW'(1);
   end

   // distance pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff <= 1'b0;
         ab_v_ff <= 1'b0;
         sq_v_ff <= 1'b0;
         d2_v_ff <= 1'b0;
      end else begin
         rd_v_ff <= scan_issue;
         ab_v_ff <= rd_v_ff;
         sq_v_ff <= ab_v_ff;
         d2_v_ff <= sq_v_ff;
      end
   end

   // absolute differences, squares, squared distance
   assign dx    = {px_ff[XY_W-1], px_ff} - {rd_plane_ff[31], rd_plane_ff[31:0]};
   assign dz    = {pz_ff[XY_W-1], pz_ff} - {rd_plane_ff[63], rd_plane_ff[63:32]};
   assign d2_in = D2_W'(sqx_ff[63:16]) + D2_W'(sqz_ff[63:16]);

   always_ff @(posedge clock) begin
      ax_ff   <= dx[XY_W] ? 32'(-dx) : dx[31:0];
      az_ff   <= dz[XY_W] ? 32'(-dz) : dz[31:0];
      y_ab_ff <= rd_height_ff;
      sqx_ff  <= 64'(ax_ff) * 64'(ax_ff);
      sqz_ff  <= 64'(az_ff) * 64'(az_ff);
      y_sq_ff <= y_ab_ff;
      d2_ff   <= d2_in;
      inr_ff  <= d2_in <= D2_W'(r2_ff);
      y_d2_ff <= y_sq_ff;
   end

   // first nearest vertex
   always_ff @(posedge clock) begin
      if (state_ff == ST_PREP) begin
         found_ff <= 1'b0;
      end else if (d2_v_ff && inr_ff && (!found_ff || d2_ff < best_ff)) begin
         found_ff  <= 1'b1;
         best_ff   <= d2_ff;
         near_y_ff <= y_d2_ff;
      end
   end

   // weight unit
   assign wreq.valid = d2_v_ff & inr_ff;
   assign wreq.d2    = d2_ff;
   assign wreq.y     = y_d2_ff;

   ths_weight_pipe u_weight (
      .clock   (clock),
      .reset   (reset),
      .in_req  (wreq),
      .out_res (wres),
      .busy    (wp_busy)
   );

   // weighted height product
   assign prod_full = $signed({1'b0, wres.w}) * wres.y;

   always_ff @(posedge clock) begin
      if (reset) mul_v_ff <= 1'b0;
      else       mul_v_ff <= wres.valid;
      prod_ff <= prod_full[63:0];
      wmul_ff <= wres.w;
   end

   // saturating weighted sum and weight sum
   assign acc_sum = {wy_sum_ff[63], wy_sum_ff} + {prod_ff[63], prod_ff};

   always_ff @(posedge clock) begin
      if (state_ff == ST_PREP) begin
         wy_sum_ff <= '0;
         w_sum_ff  <= '0;
      end else if (mul_v_ff) begin
         if (acc_sum[64] != acc_sum[63]) begin
            wy_sum_ff <= acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
         end else begin
            wy_sum_ff <= acc_sum[63:0];
         end
         w_sum_ff <= w_sum_ff + WS_W'(wmul_ff);
      end
   end

   // mean division on magnitude
   assign mag = wy_sum_ff[63] ? 64'(-wy_sum_ff) : 64'(wy_sum_ff);

   ths_mean_div #(
      .DEN_W (WS_W)
   ) u_mean_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mag),
      .divisor  (w_sum_ff),
      .done     (div_done),
      .quotient (quo)
   );

   // restore sign and clamp mean to 32 bits
   always_comb begin
      if (!wy_sum_ff[63]) begin
         if (quo > 64'h7FFF_FFFF) mean_in = 32'sh7FFF_FFFF;
         else                     mean_in = $signed(quo[31:0]);
      end else begin
         if (quo > 64'h8000_0000) mean_in = 32'sh8000_0000;
         else                     mean_in = $signed(32'(-quo));
      end
   end

   // blend 0.7 mean + 0.3 nearest, round to nearest
   assign blend_sum = {pm_ff[49], pm_ff} + {pn_ff[49], pn_ff} + 51'sd32768;

   always_ff @(posedge clock) begin
      if (state_ff == ST_DIV && div_done) mean_ff <= mean_in;
      if (state_ff == ST_BLEND) begin
         pm_ff <= BLEND_MEAN * mean_ff;
         pn_ff <= BLEND_NEAR * near_y_ff;
      end
      if (state_ff == ST_SUM) h_ff <= 35'(blend_sum >>> 16);
   end

   // snap band test
   assign top    = {{2{h_ff[34]}}, h_ff} + $signed({7'd0, sy_ff[SIZE_W-1:1]}) +
                   $signed({20'd0, tol_ff});
   assign bottom = {{2{h_ff[34]}}, h_ff} - $signed({7'd0, sy_ff[SIZE_W-1:1]});
   assign py_ext = {{5{py_ff[XY_W-1]}}, py_ff};

   always_ff @(posedge clock) begin
      if (query_take) begin
         res_hit_ff <= 1'b0;
         res_pos_ff <= req_coord_y;
         res_vel_ff <= req_velocity_y;
      end else if (state_ff == ST_CHECK && py_ext <= top && py_ext >= bottom) begin
         res_hit_ff <= 1'b1;
         res_pos_ff <= (top > 37'sd2147483647) ? 32'sh7FFF_FFFF : top[31:0];
         res_vel_ff <= '0;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_hit_ff <= res_hit_ff;
         rsp_pos_ff <= res_pos_ff;
         rsp_vel_ff <= res_vel_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_new_pos_y = rsp_pos_ff;
   assign rsp_new_vel_y = rsp_vel_ff;

endmodule

// ===== sv/ths_checker.sv =====
// ----------------------------------------------------------------------------
// ths_checker
// Port-level checks for the terrain height snap block, bound to the top.
// ----------------------------------------------------------------------------
module ths_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_op,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_hit,
   input logic signed [ths_pkg::XY_W-1:0] rsp_new_pos_y,
   input logic signed [ths_pkg::XY_W-1:0] rsp_new_vel_y
);
   import ths_pkg::*;

   // a stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) &&
      $stable(rsp_new_pos_y) && $stable(rsp_new_vel_y))
      else $error("response changed while stalled");

   // a snapped body has zero vertical velocity
   a_hit_vel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_new_vel_y == '0)
      else $error("hit with nonzero velocity");

   // a query request holds off the next request
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_op == OP_QUERY |=> !req_ready)
      else $error("request taken while query in progress");

   // no response right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind terrain_height_snap ths_checker u_ths_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_op        (req_op),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_hit       (rsp_hit),
   .rsp_new_pos_y (rsp_new_pos_y),
   .rsp_new_vel_y (rsp_new_vel_y)
);

// ===== tb/terrain_height_snap_tb.sv =====
// ----------------------------------------------------------------------------
// terrain_height_snap_tb
// Self-checking bench for the terrain height snap block. Vertex loads and
// height queries are sent over the request channel. A local model of the
// vertex store predicts each query response, and the responses are checked
// in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module terrain_height_snap_tb;
   import ths_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_DEPTH = 1024;
   localparam int IDLE_SETTLE = 60;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_3 = 2'd3;
   localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

   typedef struct {
      logic                   hit;
      logic signed [XY_W-1:0] pos_y;
      logic signed [XY_W-1:0] vel_y;
   } snap_result_type;

   // dut ports
   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic                     req_op = OP_LOAD;
   logic [IDX_W-1:0]         req_vertex_index = '0;
   logic signed [XY_W-1:0]   req_coord_x = '0;
   logic signed [XY_W-1:0]   req_coord_y = '0;
   logic signed [XY_W-1:0]   req_coord_z = '0;
   logic [SIZE_W-1:0]        req_size_x = '0;
   logic [SIZE_W-1:0]        req_size_y = '0;
   logic signed [XY_W-1:0]   req_velocity_y = '0;
   logic                     req_collision_enabled = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic                     rsp_hit;
   logic signed [XY_W-1:0]   rsp_new_pos_y;
   logic signed [XY_W-1:0]   rsp_new_vel_y;
   logic                     csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata = '0;

   // local copy of the store and registers
   logic signed [XY_W-1:0]   vert_x [STORE_DEPTH];
   logic signed [XY_W-1:0]   vert_y [STORE_DEPTH];
   logic signed [XY_W-1:0]   vert_z [STORE_DEPTH];
   int unsigned              scan_count = 0;
   int unsigned              tol_q16 = 6554;

   snap_result_type          pending_snaps[$];
   int                       fail_count = 0;
   bit                       calm = 1'b0;
   int                       hold_left = 0;

   terrain_height_snap i_dut (.*);

   always #5 clock = ~clock;

   // surface height under a body: weighted mean blended with the nearest vertex
   function automatic void surface_height(input logic signed [XY_W-1:0] px,
                                          input logic signed [XY_W-1:0] pz,
                                          input logic [SIZE_W-1:0] sx,
                                          output bit found, output longint h);
      longint unsigned r, r2, ax, az, d2, w, w_sum, best_d2, mag, q;
      longint wy_sum, term, mean, near_y, acc, dd;
      int unsigned n;
      found = 0;
      h = 0;
      w_sum = 0;
      wy_sum = 0;
      best_d2 = 0;
      near_y = 0;
      r = (longint'(sx) * 3) >> 1;
      r2 = (r * r) >> 16;
      n = (scan_count > STORE_DEPTH) ? STORE_DEPTH : scan_count;
      for (int i = 0; i < n; i++) begin
         dd = longint'(px) - longint'(vert_x[i]);
         ax = (dd < 0) ? -dd : dd;
         dd = longint'(pz) - longint'(vert_z[i]);
         az = (dd < 0) ? -dd : dd;
         d2 = ((ax * ax) >> 16) + ((az * az) >> 16);
         if (d2 <= r2) begin
            w = (64'd1 << 40) / (d2 + 66);
            if (w > 64'hFFFF_FFFF) w = 64'hFFFF_FFFF;
            if (w < 1) w = 1;
            term = longint'(w) * longint'(vert_y[i]);
            // saturating accumulate
            if (term > 0 && wy_sum > 64'sh7FFF_FFFF_FFFF_FFFF - term)
               wy_sum = 64'sh7FFF_FFFF_FFFF_FFFF;
            else if (term < 0 && wy_sum < -64'sh7FFF_FFFF_FFFF_FFFF - 1 - term)
               wy_sum = -64'sh7FFF_FFFF_FFFF_FFFF - 1;
            else
               wy_sum = wy_sum + term;
            w_sum += w;
            if (!found || d2 < best_d2) begin
               found = 1;
               best_d2 = d2;
               near_y = vert_y[i];
            end
         end
      end
      if (found) begin
         mag = (wy_sum < 0) ? -wy_sum : wy_sum;
         q = mag / w_sum;
         mean = (wy_sum < 0) ? -longint'(q) : longint'(q);
         if (mean > 64'sd2147483647) mean = 64'sd2147483647;
         if (mean < -64'sd2147483648) mean = -64'sd2147483648;
         acc = 45875 * mean + 19661 * near_y + 32768;
         h = acc >>> 16;
      end
   endfunction

   // expected response of one query
   function automatic snap_result_type predict_snap(input logic signed [XY_W-1:0] px,
      input logic signed [XY_W-1:0] py, input logic signed [XY_W-1:0] pz,
      input logic [SIZE_W-1:0] sx, input logic [SIZE_W-1:0] sy,
      input logic signed [XY_W-1:0] vel, input logic en);
      snap_result_type res;
      bit found;
      longint h, top, bottom;
      res.hit = 1'b0;
      res.pos_y = py;
      res.vel_y = vel;
      if (en) begin
         surface_height(px, pz, sx, found, h);
         top = h + longint'(sy >> 1) + longint'(tol_q16);
         bottom = h - longint'(sy >> 1);
         if (found && longint'(py) <= top && longint'(py) >= bottom) begin
            res.hit = 1'b1;
            res.pos_y = (top > 64'sd2147483647) ? 32'sh7FFF_FFFF : top[31:0];
            res.vel_y = '0;
         end
      end
      return res;
   endfunction

   // response checker
   always @(posedge clock) begin
      snap_result_type exp_res;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_snaps.size() == 0) begin
            $display("%0t: response with none expected: hit=%0b pos=%0d vel=%0d",
                     $time, rsp_hit, rsp_new_pos_y, rsp_new_vel_y);
            fail_count++;
         end else begin
            exp_res = pending_snaps.pop_front();
            if (rsp_hit !== exp_res.hit) begin
               $display("%0t: hit expected %0b actual %0b", $time, exp_res.hit, rsp_hit);
               fail_count++;
            end
            if (rsp_new_pos_y !== exp_res.pos_y) begin
               $display("%0t: new_pos_y expected %0d actual %0d",
                        $time, exp_res.pos_y, rsp_new_pos_y);
               fail_count++;
            end
            if (rsp_new_vel_y !== exp_res.vel_y) begin
               $display("%0t: new_vel_y expected %0d actual %0d",
                        $time, exp_res.vel_y, rsp_new_vel_y);
               fail_count++;
            end
         end
      end
   end

   // response side stalls, plus the long hold-off
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (!calm && $urandom_range(0, 5) == 0)
               stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 150)
                                                          : $urandom_range(1, 4);
         end
      end
   end

   // one request, held until accepted; expectation pushed on acceptance
   task automatic send_req(input logic op, input logic [IDX_W-1:0] idx,
      input logic signed [XY_W-1:0] x, input logic signed [XY_W-1:0] y,
      input logic signed [XY_W-1:0] z, input logic [SIZE_W-1:0] sx,
      input logic [SIZE_W-1:0] sy, input logic signed [XY_W-1:0] vel,
      input logic en);
      req_valid <= 1'b1;
      req_op <= op;
      req_vertex_index <= idx;
      req_coord_x <= x;
      req_coord_y <= y;
      req_coord_z <= z;
      req_size_x <= sx;
      req_size_y <= sy;
      req_velocity_y <= vel;
      req_collision_enabled <= en;
      do @(posedge clock); while (!req_ready);
      if (op == OP_LOAD) begin
         vert_x[idx] = x;
         vert_y[idx] = y;
         vert_z[idx] = z;
      end else begin
         pending_snaps.push_back(predict_snap(x, y, z, sx, sy, vel, en));
      end
   endtask

   // random gap after a request
   task automatic req_gap();
      int gap;
      gap = 0;
      if (!calm) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: gap = $urandom_range(1, 3);
            5:             gap = $urandom_range(15, 80);
            default:       gap = 0;
         endcase
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_snaps.size() != 0) @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   // one register write, enable dropped again before the task returns
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input int unsigned val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_VERTEX_COUNT) scan_count = val & 32'h7FF;
      else if (idx == REG_HEIGHT_TOL) tol_q16 = val & 32'h1FFFF;
      @(posedge clock);
   endtask

   // small random vertex around the origin
   task automatic load_random(input int slot);
      send_req(OP_LOAD, slot[IDX_W-1:0],
               $signed($urandom_range(0, 16 << 16)) - (8 <<< 16),
               $signed($urandom_range(0, 4 << 16)) - (2 <<< 16),
               $signed($urandom_range(0, 16 << 16)) - (8 <<< 16),
               SIZE_W'($urandom), SIZE_W'($urandom), $urandom, 1'($urandom));
   endtask

   // well formed query: height mostly placed in or near the snap band
   task automatic query_random();
      logic signed [XY_W-1:0] px, pz, py, vel;
      logic [SIZE_W-1:0] sx, sy;
      logic en;
      bit found;
      longint h, lo, hi, pick;
      px = $signed($urandom_range(0, 20 << 16)) - (10 <<< 16);
      pz = $signed($urandom_range(0, 20 << 16)) - (10 <<< 16);
      sx = ($urandom_range(0, 30) == 0) ? SIZE_W'($urandom)
                                         : SIZE_W'($urandom_range(1 << 14, 5 << 16));
      sy = ($urandom_range(0, 30) == 0) ? SIZE_W'($urandom)
                                         : SIZE_W'($urandom_range(0, 3 << 16));
      vel = $urandom;
      en = ($urandom_range(0, 9) != 0);
      surface_height(px, pz, sx, found, h);
      lo = h - longint'(sy >> 1) - 20000;
      hi = h + longint'(sy >> 1) + longint'(tol_q16) + 20000;
      pick = lo + longint'($urandom_range(0, 32'(hi - lo)));
      if (found && $urandom_range(0, 4) != 0) begin
         if (pick > 64'sd2147483647) pick = 64'sd2147483647;
         if (pick < -64'sd2147483648) pick = -64'sd2147483648;
         py = pick[31:0];
      end else begin
         py = $urandom;
      end
      send_req(OP_QUERY, '0, px, py, pz, sx, sy, vel, en);
   endtask

   // extremes, empty store, tie, disabled body, saturated snap, spare registers
   task automatic test_directed();
      calm = 1'b1;
      send_req(OP_QUERY, '0, 0, Q_ONE, 0, Q_ONE, Q_ONE, Q_ONE, 1'b1);
      send_req(OP_LOAD, 10'd0, Q_ONE, Q_ONE, 0, 0, 0, 0, 1'b0);
      send_req(OP_LOAD, 10'd1, -Q_ONE, 3 * Q_ONE, 0, '1, '1, '1, 1'b1);
      send_req(OP_LOAD, 10'd2, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 0, 0);
      send_req(OP_LOAD, 10'd3, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 0, 0);
      send_req(OP_LOAD, 10'd1023, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
               0, 0, 0, 0);
      wait_idle();
      csr_write(REG_VERTEX_COUNT, 4);
      csr_write(REG_HEIGHT_TOL, 0);
      csr_write(REG_SPARE_2, 32'h1FFFF);
      csr_write(REG_SPARE_3, 32'h1FFFF);
      // equal distance to slots 0 and 1
      send_req(OP_QUERY, '0, 0, 2 * Q_ONE, 0, Q_ONE, Q_ONE, 32'sh8000_0000, 1'b1);
      send_req(OP_QUERY, '0, 0, 2 * Q_ONE, 0, Q_ONE, Q_ONE, 32'sh7FFF_FFFF, 1'b0);
      send_req(OP_QUERY, '0, Q_ONE, Q_ONE, 0, '0, '0, Q_ONE, 1'b1);
      send_req(OP_QUERY, '0, 32'sh7FFF_FFFF, 0, 32'sh8000_0000, '1, '1, '1, 1'b1);
      send_req(OP_QUERY, '0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
               '1, '1, 0, 1'b1);
      send_req(OP_QUERY, '0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
               '0, '1, 0, 1'b1);
      wait_idle();
      csr_write(REG_HEIGHT_TOL, 65536);
      send_req(OP_LOAD, 10'd0, 0, 32'sh7FFF_0000, 0, 0, 0, 0, 0);
      wait_idle();
      csr_write(REG_VERTEX_COUNT, 1);
      // snap height beyond the top of the range
      send_req(OP_QUERY, '0, 0, 32'sh7FFF_FFFF, 0, Q_ONE, '1, 32'sh8000_0000, 1'b1);
      send_req(OP_QUERY, '0, 0, 32'sh7FFF_0000, 0, Q_ONE, '0, -Q_ONE, 1'b1);
      wait_idle();
      csr_write(REG_VERTEX_COUNT, 0);
      send_req(OP_QUERY, '0, 0, 32'sh7FFF_0000, 0, '1, Q_ONE, -Q_ONE, 1'b1);
      wait_idle();
      calm = 1'b0;
   endtask

   // random loads and queries over a small store, settings changed between phases
   task automatic test_random();
      for (int i = 0; i < 128; i++) begin
         load_random(i);
         req_gap();
      end
      for (int n = 0; n < 420; n++) begin
         if (n % 60 == 0) begin
            wait_idle();
            csr_write(REG_VERTEX_COUNT, $urandom_range(0, 128));
            case ($urandom_range(0, 3))
               0:       csr_write(REG_HEIGHT_TOL, 0);
               1:       csr_write(REG_HEIGHT_TOL, 65536);
               default: csr_write(REG_HEIGHT_TOL, $urandom_range(0, 65536));
            endcase
         end
         // long response hold-off while requests keep coming
         if (n == 200) hold_left = 3000;
         if ($urandom_range(0, 9) < 3) load_random($urandom_range(0, 127));
         else query_random();
         req_gap();
      end
      wait_idle();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #20ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/ths_pkg.sv
sv/ths_weight_pipe.sv
sv/ths_mean_div.sv
sv/terrain_height_snap.sv
sv/ths_checker.sv
tb/terrain_height_snap_tb.sv
